// ----- sv/hpao_pkg.sv -----
// Shared types, widths and helpers for the heater PWM / converter oversampler.
// No dependencies.
package hpao_pkg;

    localparam int unsigned DUTY_W = 8;
    localparam int unsigned ADC_W  = 10;
    localparam int unsigned SUM_W  = 14;

    typedef enum logic [1:0] {
        PH_START_HOT = 2'd0,
        PH_READ_HOT  = 2'd1,
        PH_START_BED = 2'd2,
        PH_READ_BED  = 2'd3
    } phase_t;

    typedef struct packed {
        logic             start;
        logic             channel;
        logic             ready;
        logic [SUM_W-1:0] hot_sum;
        logic [SUM_W-1:0] bed_sum;
    } seq_out_t;

    // Saturating accumulate at the full-scale of the sum width.
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                 input logic [ADC_W-1:0] v);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + (SUM_W+1)'(v);
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

// ----- sv/heater_pwm_adc_oversampler.sv -----
// Heater soft-PWM driver with interleaved, oversampling converter sequencer.
// Depends on hpao_pkg, hpao_pwm and hpao_seq.
//
// Usage:
//   Each request on the item channel (item_valid / item_stall) is one timer
//   tick carrying both heater duties and the latest converter result. Every
//   request yields exactly one result on the result channel (result_valid /
//   result_stall) with both heater drive levels, the converter start/channel
//   command and, once per oversample period, both raw sums with sample_ready.
// A request is captured in the input register, processed in one pass through
//   the PWM compare and sequencer logic, and then lands in the result
//   register.
// Throughput: one request per clock while result_stall is low; the input
//   register and the result register form a two-entry pipeline.
// Stall: while result_stall holds a result, the input register drains into
//   the result register only when that register frees up; item_stall rises
//   once the input register holds a request that cannot move.
// Reset: PWM counter, sequencer phase (start hotend conversion), oversample
//   index and both accumulators clear; both channels come up empty.
// A conversion started by one tick must be delivered in adc_result of the
//   following tick.
module heater_pwm_adc_oversampler #(
    parameter int unsigned OVERSAMPLES = 16,
    parameter int unsigned ADC_BITS    = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [hpao_pkg::DUTY_W-1:0] hotend_duty,
    input  logic [hpao_pkg::DUTY_W-1:0] bed_duty,
    input  logic [hpao_pkg::ADC_W-1:0]  adc_result,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic                        hotend_heater_on,
    output logic                        bed_heater_on,
    output logic                        adc_start,
    output logic                        adc_channel,
    output logic                        sample_ready,
    output logic [hpao_pkg::SUM_W-1:0]  hotend_raw_sum,
    output logic [hpao_pkg::SUM_W-1:0]  bed_raw_sum
);
    import hpao_pkg::*;

    // input register
    logic              s1_valid_reg;
    logic [DUTY_W-1:0] hot_duty_reg;
    logic [DUTY_W-1:0] bed_duty_reg;
    logic [ADC_W-1:0]  adc_reg;

    // result register
    logic              out_valid_reg;
    logic              hot_on_reg;
    logic              bed_on_reg;
    seq_out_t          seq_reg;

    logic              out_free;
    logic              advance;
    logic              take;
    logic              hot_on;
    logic              bed_on;
    seq_out_t          seq_res;

    assign out_free   = !out_valid_reg || !result_stall;
    assign advance    = s1_valid_reg && out_free;    // tick processed this cycle
    assign item_stall = s1_valid_reg && !out_free;
    assign take       = item_valid && !item_stall;

    hpao_pwm u_pwm (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .hotend_duty (hot_duty_reg),
        .bed_duty    (bed_duty_reg),
        .hotend_on   (hot_on),
        .bed_on      (bed_on)
    );

    hpao_seq #(
        .OVERSAMPLES (OVERSAMPLES),
        .ADC_BITS    (ADC_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .adc_result (adc_reg),
        .res        (seq_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hot_duty_reg <= hotend_duty;
            bed_duty_reg <= bed_duty;
            adc_reg      <= adc_result;
        end
        if (advance)
        begin
            hot_on_reg <= hot_on;
            bed_on_reg <= bed_on;
            seq_reg    <= seq_res;
        end
    end

    assign result_valid     = out_valid_reg;
    assign hotend_heater_on = hot_on_reg;
    assign bed_heater_on    = bed_on_reg;
    assign adc_start        = seq_reg.start;
    assign adc_channel      = seq_reg.channel;
    assign sample_ready     = seq_reg.ready;
    assign hotend_raw_sum   = seq_reg.hot_sum;
    assign bed_raw_sum      = seq_reg.bed_sum;

endmodule

// ----- sv/hpao_pwm.sv -----
// Step-enabled 8-bit PWM counter with two strict less-than duty compares.
// Depends on hpao_pkg.
module hpao_pwm (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [hpao_pkg::DUTY_W-1:0] hotend_duty,
    input  logic [hpao_pkg::DUTY_W-1:0] bed_duty,
    output logic                       hotend_on,
    output logic                       bed_on
);
    import hpao_pkg::*;

    logic [DUTY_W-1:0] count_reg;
    logic [DUTY_W-1:0] count_next;

    // strict compare: duty 0 is fully off
    assign hotend_on  = count_reg < hotend_duty;
    assign bed_on     = count_reg < bed_duty;
    assign count_next = count_reg + DUTY_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (step)
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ----- sv/hpao_seq.sv -----
// Four-phase converter sequencer with hotend/bed oversampling accumulators.
// Depends on hpao_pkg.
module hpao_seq #(
    parameter int unsigned OVERSAMPLES = 16,
    parameter int unsigned ADC_BITS    = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [hpao_pkg::ADC_W-1:0] adc_result,
    output hpao_pkg::seq_out_t         res
);
    import hpao_pkg::*;

    localparam int unsigned OS_EFF   = (OVERSAMPLES < 1) ? 1 : OVERSAMPLES;
    localparam int unsigned IDX_W    = (OS_EFF > 1) ? $clog2(OS_EFF) : 1;
    localparam int unsigned ADC_KEEP = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
    localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((33'd1 << ADC_KEEP) - 33'd1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(OS_EFF - 1);

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [SUM_W-1:0] hot_reg, hot_next;
    logic [SUM_W-1:0] bed_reg, bed_next;
    logic [ADC_W-1:0] adc;
    logic [SUM_W-1:0] bed_sum;

    assign adc     = adc_result & ADC_MASK;
    assign bed_sum = sat_add(bed_reg, adc);

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        hot_next   = hot_reg;
        bed_next   = bed_reg;
        res        = '0;
        case (phase_reg)
            PH_START_HOT:
            begin
                res.start  = 1'b1;
                phase_next = PH_READ_HOT;
            end
            PH_READ_HOT:
            begin
                hot_next   = sat_add(hot_reg, adc);
                phase_next = PH_START_BED;
            end
            PH_START_BED:
            begin
                res.start   = 1'b1;
                res.channel = 1'b1;
                phase_next  = PH_READ_BED;
            end
            PH_READ_BED:
            begin
                res.channel = 1'b1;
                phase_next  = PH_START_HOT;
                if (idx_reg == IDX_LAST)
                begin
                    // period complete: present sums and clear
                    res.ready   = 1'b1;
                    res.hot_sum = hot_reg;
                    res.bed_sum = bed_sum;
                    idx_next    = '0;
                    hot_next    = '0;
                    bed_next    = '0;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    bed_next = bed_sum;
                end
            end
            default:
            begin
                phase_next = PH_START_HOT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START_HOT;
            idx_reg   <= '0;
            hot_reg   <= '0;
            bed_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            hot_reg   <= hot_next;
            bed_reg   <= bed_next;
        end
    end

endmodule
